/* sv/ggsh_pkg.sv */
// ============================================================================
// ggsh_pkg
// Shared widths, constants and the control struct for the gated glide
// sample-and-hold block.
// ============================================================================
package ggsh_pkg;

   localparam int VALUE_W      = 32;
   localparam int RATE_W       = 18;
   localparam int SECS_W       = 32;
   localparam int T_W          = 17;   // Q1.16
   localparam int T_FRAC       = 16;
   localparam int DEF_VALUE_FRAC_BITS = 16;
   localparam int DEF_FRAME_BITS      = 32;
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
   localparam logic [T_W-1:0]    T_ONE      = T_W'(65536);

   // Serial multiplier handshake
   typedef struct packed {
      logic start;
   } mul_ctl_type;

endpackage

/* sv/ggsh_if.sv */
// ============================================================================
// ggsh_req_if / ggsh_rsp_if
// Valid/ready channels for sample beats and result beats.
// ============================================================================
interface ggsh_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [ggsh_pkg::VALUE_W-1:0] sample_value;
   logic                            gate_high;
   logic [ggsh_pkg::SECS_W-1:0]     glide_seconds;
   modport source (output valid, sample_value, gate_high, glide_seconds, input ready);
   modport sink   (input valid, sample_value, gate_high, glide_seconds, output ready);
endinterface

interface ggsh_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [ggsh_pkg::VALUE_W-1:0] linear_out;
   logic signed [ggsh_pkg::VALUE_W-1:0] smooth_out;
   modport source (output valid, linear_out, smooth_out, input ready);
   modport sink   (input valid, linear_out, smooth_out, output ready);
endinterface

/* sv/gated_glide_sample_hold.sv */
// ============================================================================
// gated_glide_sample_hold
// Sample and hold with portamento glide: linear and eased outputs.
// ============================================================================
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    sample_value, gate_high, glide_seconds
// rsp      out  valid/ready    linear_out, smooth_out
// csr      in   write enable   sample_rate_hz (18 bits)
//
// One beat at a time, the next accept only after the result is taken: an
// 18-step serial multiply for the glide length, 16 divide steps, then nine
// 34-step serial multiplies (five for the easing curve, four for the two
// blends); each unit is started by a registered strobe and flags done.
// Reset is synchronous; it clears control state and the glide state.
// req_ready stays low from acceptance until the result beat has been taken.
// ============================================================================
module gated_glide_sample_hold #(
   parameter int VALUE_FRAC_BITS = ggsh_pkg::DEF_VALUE_FRAC_BITS,
   parameter int FRAME_BITS      = ggsh_pkg::DEF_FRAME_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   ggsh_req_if.sink                       req,
   ggsh_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [ggsh_pkg::RATE_W-1:0]    csr_write_data
);
   localparam int L_W = ggsh_pkg::SECS_W + ggsh_pkg::RATE_W;       // 50
   localparam int N_W = (FRAME_BITS + 16 > L_W) ? FRAME_BITS + 16 : L_W;
   localparam int M_W = 34;  // serial operand width for blends/easing
   localparam int P_W = 2 * M_W;
   localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

   localparam logic [3:0] S_IDLE = 4'd0, S_LEN = 4'd1, S_DIV = 4'd2,
      S_T2 = 4'd3, S_A1 = 4'd4, S_A2 = 4'd5, S_T4 = 4'd6, S_T5 = 4'd7,
      S_BL = 4'd8, S_OUT = 4'd9;

   logic [3:0] st_ff, st_in;
   logic [3:0] sub_ff, sub_in;    // blend step: 0..3
   logic go_ff, go_in;
   logic [ggsh_pkg::RATE_W-1:0] rate_ff;
   logic prev_gate_ff;
   logic signed [31:0] tgt_ff, start_ff, last_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic [31:0] secs_ff;
   logic [L_W-1:0] len_ff;
   logic [16:0] t_ff, t2_ff, t4_ff, e_ff;
   logic [18:0] a_ff;
   logic signed [P_W:0] s_ff;
   logic signed [31:0] lin_ff, smo_ff;
   logic rsp_valid_ff;

   ggsh_pkg::mul_ctl_type mctl;
   logic [M_W-1:0] ma, mb;
   logic [2*M_W-1:0] mp;
   logic mdone;
   logic dstart, ddone;
   logic [15:0] dq;
   logic [N_W-1:0] num;
   logic [N_W-1:0] div_num;
   logic [N_W-1:0] len_w;
   logic [L_W-1:0] len_clip;
   logic num_lt;
   logic [16:0] rnd;
   logic [17:0] e_sum;
   logic [32:0] sa, sb;   // magnitudes for blend
   logic        sneg;
   logic signed [P_W:0] s_term;
   logic signed [P_W:0] s_fin;
   logic signed [31:0] blend_q;
   logic [16:0] w_cur;

   // serial multipliers: one for the glide length, one for easing and blends
   logic [L_W-1:0] lp;
   logic ldone;
   ggsh_pkg::mul_ctl_type lctl;
   ggsh_mul #(.A_W(32), .B_W(ggsh_pkg::RATE_W)) u_len (
      .clock, .reset, .ctl(lctl), .a(secs_ff), .b(rate_ff), .prod(lp), .done(ldone));
   ggsh_mul #(.A_W(M_W), .B_W(M_W)) u_mul (
      .clock, .reset, .ctl(mctl), .a(ma), .b(mb), .prod(mp), .done(mdone));
   ggsh_div #(.L_W(N_W)) u_div (
      .clock, .reset, .start(dstart), .num(div_num), .len(len_w), .quot(dq),
      .done(ddone));

   assign num    = N_W'(frame_ff) << 16;
   assign len_w  = N_W'(len_ff);
   assign num_lt = num < len_w;
   // feed zero once the glide is complete; the quotient is not used then
   assign div_num = num_lt ? num : '0;
   assign len_clip = (lp < L_W'(65536)) ? L_W'(65536) : lp;
   assign rnd    = 17'((mp + (2*M_W)'(32768)) >> 16);
   assign e_sum  = 18'(a_ff) + 18'(rnd);
   assign w_cur  = (sub_ff[1]) ? e_ff : t_ff;

   // blend operand: sub 0 -> start*(1-w), sub 1 -> target*w
   always_comb begin
      if (sub_ff[0]) begin
         sneg = tgt_ff[31];
         sa   = sneg ? 33'(-{tgt_ff[31], tgt_ff}) : 33'({1'b0, tgt_ff});
         sb   = 33'(w_cur);
      end else begin
         sneg = start_ff[31];
         sa   = sneg ? 33'(-{start_ff[31], start_ff}) : 33'({1'b0, start_ff});
         sb   = 33'(ggsh_pkg::T_ONE - w_cur);
      end
   end
   assign s_term  = sneg ? -$signed({1'b0, mp}) : $signed({1'b0, mp});
   assign s_fin   = s_ff + s_term + (P_W+1)'(32768);
   assign blend_q = 32'(s_fin >>> 16);

   // operands and start strobes for the serial units
   always_comb begin
      ma = '0; mb = '0; mctl.start = 1'b0; lctl.start = 1'b0; dstart = 1'b0;
      case (st_ff)
         S_T2: begin ma = M_W'(t_ff);  mb = M_W'(t_ff); end
         S_A1: begin ma = M_W'(t2_ff); mb = M_W'(5); end
         S_A2: begin ma = M_W'(a_ff);  mb = M_W'(ggsh_pkg::T_ONE - t_ff); end
         S_T4: begin ma = M_W'(t2_ff); mb = M_W'(t2_ff); end
         S_T5: begin ma = M_W'(t4_ff); mb = M_W'(t_ff); end
         S_BL: begin ma = M_W'(sa);    mb = M_W'(sb); end
         default: ;
      endcase
      if (go_ff && st_ff == S_LEN) lctl.start = 1'b1;
      if (go_ff && st_ff == S_DIV) dstart = 1'b1;
      if (go_ff && st_ff >= S_T2 && st_ff <= S_BL) mctl.start = 1'b1;
   end

   // sequencer: advance one unit at a time
   always_comb begin
      st_in = st_ff; sub_in = sub_ff;
      case (st_ff)
         S_IDLE: if (req.valid) st_in = S_LEN;
         S_LEN:  if (ldone) st_in = S_DIV;
         S_DIV:  if (ddone) st_in = S_T2;
         S_T2:   if (mdone) st_in = S_A1;
         S_A1:   if (mdone) st_in = S_A2;
         S_A2:   if (mdone) st_in = S_T4;
         S_T4:   if (mdone) st_in = S_T5;
         S_T5:   if (mdone) begin st_in = S_BL; sub_in = '0; end
         S_BL:   if (mdone) begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 4'd3) st_in = S_OUT;
         end
         S_OUT:  if (rsp.ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // registered start strobe, high as each unit's step begins, with operands selected by that step
   assign go_in = (st_in != st_ff && st_in >= S_LEN && st_in <= S_BL) ||
                  (st_ff == S_BL && mdone && st_in == S_BL);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         sub_ff <= '0;
         go_ff <= 1'b0;
         rate_ff <= ggsh_pkg::RATE_RESET;
         prev_gate_ff <= 1'b0;
         tgt_ff <= '0; start_ff <= '0; last_ff <= '0;
         frame_ff <= '0;
      end else begin
         st_ff <= st_in;
         sub_ff <= sub_in;
         go_ff <= go_in;
         if (csr_write_enable) rate_ff <= csr_write_data;
         // capture on rising gate
         if (st_ff == S_IDLE && req.valid) begin
            prev_gate_ff <= req.gate_high;
            if (!prev_gate_ff && req.gate_high) begin
               tgt_ff <= req.sample_value;
               start_ff <= last_ff;
               frame_ff <= '0;
            end
         end
         // linear result done: save it, advance counter
         if (st_ff == S_BL && mdone && sub_ff == 4'd1) begin
            last_ff <= blend_q;
            if (num_lt && frame_ff != FRAME_MAX) frame_ff <= frame_ff + 1'b1;
         end
      end
      if (st_ff == S_IDLE && req.valid) secs_ff <= req.glide_seconds;
      if (st_ff == S_LEN && ldone) len_ff <= len_clip;
      if (ddone) t_ff <= num_lt ? {1'b0, dq} : ggsh_pkg::T_ONE;
      if (st_ff == S_T2 && mdone) t2_ff <= rnd;
      if (st_ff == S_A1 && mdone) a_ff <= 19'(mp);
      if (st_ff == S_A2 && mdone) a_ff <= 19'(rnd);
      if (st_ff == S_T4 && mdone) t4_ff <= rnd;
      if (st_ff == S_T5 && mdone)
         e_ff <= (e_sum > 18'(ggsh_pkg::T_ONE)) ? ggsh_pkg::T_ONE : 17'(e_sum);
      if (st_ff == S_BL && mdone) begin
         if (sub_ff[0]) begin
            s_ff <= '0;
            if (sub_ff[1]) smo_ff <= blend_q; else lin_ff <= blend_q;
         end else begin
            s_ff <= s_term;
         end
      end
   end

   // t only needs the divider when num < len; the divide still runs otherwise
   assign rsp_valid_ff = (st_ff == S_OUT);
   assign req.ready    = (st_ff == S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.linear_out = lin_ff;
   assign rsp.smooth_out = smo_ff;

   one_unit_a: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("accept while result pending");
   e_range_a: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_BL |-> e_ff <= ggsh_pkg::T_ONE) else $error("ease out of range");
   len_min_a: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DIV |-> len_ff >= L_W'(65536)) else $error("glide length below one");
   accept_go_a: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> st_ff == S_LEN) else $error("accept lost");

   logic unused_frac;
   assign unused_frac = (VALUE_FRAC_BITS > 0);

endmodule

/* sv/ggsh_mul.sv */
// ============================================================================
// ggsh_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ============================================================================
module ggsh_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ggsh_pkg::mul_ctl_type ctl,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic [A_W+B_W-1:0]   prod,
   output logic                 done
);
   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W+B_W-1:0] acc_ff, acc_in;
   logic [B_W-1:0]     b_ff, b_in;
   logic [A_W+B_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // Add the shifted multiplicand for each set bit, LSB first
   always_comb begin
      acc_in  = acc_ff;
      b_in    = b_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         acc_in  = '0;
         a_in    = (A_W+B_W)'(a);
         b_in    = b;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   // Flag the product once the last partial sum has landed
   assign done_in = busy_ff && (cnt_ff == CNT_W'(1)) && !ctl.start;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;

   cnt_range_a: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("mul count underflow");
   start_load_a: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff) else $error("mul did not start");
   done_idle_a: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff) else $error("mul busy at done");

endmodule

/* sv/ggsh_div.sv */
// ============================================================================
// ggsh_div
// Restoring divider for t = floor(num * 2^16 / len), one quotient bit a cycle.
// ============================================================================
module ggsh_div #(
   parameter int L_W = 50
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [L_W-1:0]  num,
   input  logic [L_W-1:0]  len,
   output logic [15:0]     quot,
   output logic            done
);
   logic [L_W:0]   r_ff, r_in;
   logic [L_W-1:0] d_ff, d_in;
   logic [15:0]    q_ff, q_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [L_W:0]   r_sh;

   // Shift remainder, subtract when it fits
   always_comb begin
      r_in = r_ff; d_in = d_ff; q_in = q_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      r_sh = r_ff << 1;
      if (start) begin
         r_in = (L_W+1)'(num); d_in = len; q_in = '0;
         cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (r_sh >= (L_W+1)'(d_ff)) begin
            r_in = r_sh - (L_W+1)'(d_ff);
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = r_sh;
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   // Flag the quotient once the last bit has landed
   assign done_in = busy_ff && (cnt_ff == 5'd1) && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      r_ff <= r_in;
      d_ff <= d_in;
      q_ff <= q_in;
   end

   assign quot = q_ff;
   assign done = done_ff;

   div_cnt_a: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("div count underflow");
   div_rem_a: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != 5'd16) |-> r_ff < (L_W+1)'(d_ff)) else $error("div rem");
   div_start_a: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("div did not start");

endmodule

/* tb/sv/tb_gated_glide_sample_hold.sv */
// ============================================================================
// tb_gated_glide_sample_hold
// Drives sample beats with bursts and gaps, stalls the result channel, and
// checks every result beat against a cycle-free glide/ease predictor across
// several sample-rate settings.
// ============================================================================
module tb_gated_glide_sample_hold;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               gate_high;
      logic [31:0]        glide_seconds;
   } sample_beat_type;

   typedef struct packed {
      logic signed [31:0] linear_out;
      logic signed [31:0] smooth_out;
   } glide_result_type;

   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [ggsh_pkg::RATE_W-1:0] csr_write_data = '0;

   ggsh_req_if req ();
   ggsh_rsp_if rsp ();

   gated_glide_sample_hold dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // predictor state
   logic [ggsh_pkg::RATE_W-1:0] rate_hz;
   logic              prev_gate;
   logic signed [31:0] target_val, start_val, last_linear;
   logic [31:0]       frame_cnt;

   sample_beat_type  pending_beats[$];
   glide_result_type expected_results[$];
   int  mismatch_count = 0;
   int  error_count = 0;
   longint cycle_count = 0;
   bit  hold_sender = 1'b0;
   bit  long_stall_req = 1'b0;
   bit  stall_active = 1'b0;
   bit  req_taken = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("gated_glide_sample_hold test failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] blend_q16(logic signed [31:0] a,
         logic signed [31:0] b, logic [16:0] w);
      logic signed [65:0] s;
      s = $signed({{34{a[31]}}, a}) * $signed({49'd0, 17'(ggsh_pkg::T_ONE - w)})
        + $signed({{34{b[31]}}, b}) * $signed({49'd0, w}) + 66'sd32768;
      return 32'(s >>> 16);
   endfunction

   function automatic logic [31:0] round16(logic [63:0] p);
      return 32'((p + 64'd32768) >> 16);
   endfunction

   function automatic logic [16:0] ease_curve(logic [16:0] t);
      logic [31:0] t2, a, t4, t5, e;
      t2 = round16(64'(t) * 64'(t));
      a  = round16(64'd5 * 64'(t2) * 64'(17'(ggsh_pkg::T_ONE - t)));
      t4 = round16(64'(t2) * 64'(t2));
      t5 = round16(64'(t4) * 64'(t));
      e  = a + t5;
      return (e > 32'(ggsh_pkg::T_ONE)) ? ggsh_pkg::T_ONE : e[16:0];
   endfunction

   // advance glide state for one accepted sample beat
   function automatic glide_result_type predict_glide(sample_beat_type b);
      glide_result_type r;
      logic [63:0] len, num;
      logic [16:0] t;
      if (!prev_gate && b.gate_high) begin
         target_val = b.sample_value;
         start_val  = last_linear;
         frame_cnt  = '0;
      end
      prev_gate = b.gate_high;
      len = 64'(b.glide_seconds) * 64'(rate_hz);
      if (len < 64'd65536) len = 64'd65536;
      num = 64'(frame_cnt) << 16;
      if (num >= len) t = ggsh_pkg::T_ONE;
      else t = 17'((num << 16) / len);
      last_linear = blend_q16(start_val, target_val, t);
      r.linear_out = last_linear;
      r.smooth_out = blend_q16(start_val, target_val, ease_curve(t));
      if (num < len && frame_cnt != 32'hFFFF_FFFF) frame_cnt = frame_cnt + 1;
      return r;
   endfunction

   // note an accepted sample beat at the rising edge
   always @(posedge clock) req_taken = !reset && req.valid && req.ready;

   // driver: bursts and gaps at the falling edge
   int gap_left = 0, burst_left = 0;
   initial begin
      req.valid = 1'b0;
      req.sample_value = '0;
      req.gate_high = 1'b0;
      req.glide_seconds = '0;
   end
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken)
            expected_results.push_back(predict_glide(pending_beats.pop_front()));
         if (!req.valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (pending_beats.size() > 0 && !hold_sender) begin
               req.valid <= 1'b1;
               req.sample_value <= pending_beats[0].sample_value;
               req.gate_high <= pending_beats[0].gate_high;
               req.glide_seconds <= pending_beats[0].glide_seconds;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with an optional long hold-off
   int stall_phase = 0;
   int long_hold = 0;
   initial rsp.ready = 1'b0;
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (long_stall_req && long_hold == 0 && !stall_active) begin
         stall_active = 1'b1;
         long_hold = 3000;
         rsp.ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp.ready <= 1'b0;
         if (long_hold == 0) stall_active = 1'b0;
      end else begin
         stall_phase = (stall_phase + 1) % 23;
         rsp.ready <= (stall_phase < 15) ? ($urandom_range(0, 5) != 0) : 1'b1;
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      glide_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result beat %h %h",
               rsp.linear_out, rsp.smooth_out);
         end else begin
            exp_r = expected_results.pop_front();
            if (exp_r.linear_out !== rsp.linear_out ||
                exp_r.smooth_out !== rsp.smooth_out) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected lin %h smo %h, got lin %h smo %h",
                     exp_r.linear_out, exp_r.smooth_out, rsp.linear_out, rsp.smooth_out);
            end
         end
      end
   end

   function automatic sample_beat_type rand_beat(bit gate, int secs_mode);
      sample_beat_type b;
      b.sample_value = $urandom;
      b.gate_high = gate;
      case (secs_mode)
         0: b.glide_seconds = $urandom_range(0, 3);
         1: b.glide_seconds = $urandom_range(0, 32'h0000_0800);
         2: b.glide_seconds = $urandom_range(0, 32'h0004_0000) >> 5;
         default: b.glide_seconds = $urandom;
      endcase
      return b;
   endfunction

   task automatic wait_drained();
      while (pending_beats.size() != 0 || req.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_rate(logic [ggsh_pkg::RATE_W-1:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      rate_hz = v;
   endtask

   initial begin
      sample_beat_type b;
      logic [ggsh_pkg::RATE_W-1:0] rates[6];
      int mode;
      rate_hz = ggsh_pkg::RATE_RESET;
      prev_gate = 1'b0;
      target_val = '0; start_val = '0; last_linear = '0; frame_cnt = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, zero time, gate edges, hold and fall
      b = '{32'sh7FFF_FFFF, 1'b1, 32'd0};          pending_beats.push_back(b);
      b = '{32'sh7FFF_FFFF, 1'b1, 32'd0};          pending_beats.push_back(b);
      b = '{32'sh8000_0000, 1'b0, 32'hFFFF_FFFF};  pending_beats.push_back(b);
      b = '{32'sh8000_0000, 1'b1, 32'hFFFF_FFFF};  pending_beats.push_back(b);
      b = '{32'sh0000_0000, 1'b1, 32'hFFFF_FFFF};  pending_beats.push_back(b);
      b = '{32'sh0000_0000, 1'b0, 32'h0000_0001};  pending_beats.push_back(b);
      b = '{32'sh1234_5678, 1'b1, 32'h0000_0002};  pending_beats.push_back(b);
      for (int i = 0; i < 8; i++) begin
         b = '{32'shFFFF_0000, 1'b1, 32'h0000_0002};  pending_beats.push_back(b);
      end
      b = '{32'shFFFF_FFFF, 1'b0, 32'h0001_0000};  pending_beats.push_back(b);
      b = '{32'sh0001_0000, 1'b1, 32'h0000_0010};  pending_beats.push_back(b);
      for (int i = 0; i < 5; i++) begin
         b = '{32'sh5555_AAAA, 1'b1, 32'h0000_0010};  pending_beats.push_back(b);
      end
      wait_drained();

      rates = '{18'd1, 18'd192000, 18'd0, 18'h3FFFF, 18'd48000, 18'd8};
      for (int p = 0; p < 6; p++) begin
         write_rate(rates[p]);
         for (int n = 0; n < 30; n++) begin
            mode = $urandom_range(0, 9);
            // mostly: rising edge then a held gate for a short glide
            if (mode < 7) begin
               pending_beats.push_back(rand_beat(1'b0, $urandom_range(0, 3)));
               pending_beats.push_back(rand_beat(1'b1, $urandom_range(0, 2)));
               b = pending_beats[$];
               for (int k = $urandom_range(0, 6); k > 0; k--) begin
                  b.sample_value = $urandom;
                  pending_beats.push_back(b);
               end
            end else begin
               pending_beats.push_back(rand_beat($urandom_range(0, 1), $urandom_range(0, 3)));
            end
            // long receiver hold-off while beats are still queued
            if (n == 10 && p == 1) begin
               long_stall_req = 1'b1;
               @(posedge clock);
               long_stall_req = 1'b0;
            end
            while (pending_beats.size() > 40) @(posedge clock);
         end
         if (p == 2) begin
            hold_sender = 1'b1;
            while (req.valid || expected_results.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      if (mismatch_count == 0 && error_count == 0 && expected_results.size() == 0)
         $display("gated_glide_sample_hold test passed");
      else
         $display("gated_glide_sample_hold test failed");
      $finish;
   end

endmodule
